// ===== rtl/glr_pkg.sv =====
// ----------------------------------------------------------------------------
// glr_pkg - shared types and constants of the grid line rasterizer
// word layouts, sequencer states and the step unit's interface structs
// ----------------------------------------------------------------------------
package glr_pkg;

    localparam int GRID_SIZE = 64;
    localparam int COORD_W   = $clog2(GRID_SIZE);
    // error is scaled by 2|dx|; it grows by at most 2|dy| per x step
    localparam int ERR_W     = 2 * COORD_W + 4;

    typedef logic [COORD_W-1:0]      t_coord;
    typedef logic signed [ERR_W-1:0] t_err;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        logic   paint_value;
    } t_in_word;

    typedef struct packed {
        t_coord cell_x;
        t_coord cell_y;
        logic   cell_value;
        logic   last_cell;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN
    } t_state;

    // walker state handed to the step unit
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_err   err;
        t_coord end_x;
        t_coord end_y;
        t_coord abs_dx;
        t_coord abs_dy;
        logic   up_x;
        logic   up_y;
    } t_step_in;

    // walker state after one emitted cell
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_err   err;
        logic   last;
    } t_step_out;

endpackage

// ===== rtl/glr_step.sv =====
// ----------------------------------------------------------------------------
// glr_step - one step of the line walker
// advances x with an integer error term, or y alone in the trailing run
// ----------------------------------------------------------------------------
module glr_step
    import glr_pkg::*;
(
    input  t_step_in  i_cur,
    output t_step_out o_nxt
);

    logic x_run;
    t_err err_add;
    t_err err_sub;
    t_err dx_ext;
    t_err dy2_ext;
    logic y_step;
    t_coord y_inc;
    t_coord x_inc;

    assign dx_ext  = t_err'({1'b0, i_cur.abs_dx});
    assign dy2_ext = t_err'({1'b0, i_cur.abs_dy, 1'b0});

    assign x_run   = (i_cur.x != i_cur.end_x);
    assign err_add = i_cur.err + dy2_ext;
    assign err_sub = err_add - (dx_ext <<< 1);
    // error at or above one half
    assign y_step  = (err_add >= dx_ext);

    assign x_inc = i_cur.up_x ? i_cur.x + 1'b1 : i_cur.x - 1'b1;
    assign y_inc = i_cur.up_y ? i_cur.y + 1'b1 : i_cur.y - 1'b1;

    always_comb begin
        if (x_run) begin
            o_nxt.x   = x_inc;
            o_nxt.y   = (y_step && (i_cur.y != i_cur.end_y)) ? y_inc : i_cur.y;
            o_nxt.err = y_step ? err_sub : err_add;
        end else begin
            o_nxt.x   = i_cur.x;
            o_nxt.y   = y_inc;
            o_nxt.err = i_cur.err;
        end
        o_nxt.last = (o_nxt.x == i_cur.end_x) && (o_nxt.y == i_cur.end_y);
    end

endmodule

// ===== rtl/grid_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// grid_line_rasterizer - walks the grid cells of a line toward an end cell
// sequencer around a shared step unit, one cell per cycle while the output is not stalled, into an out register
// ----------------------------------------------------------------------------
// usage:
//   input channel: one word holds start cell, end cell and paint value; it is
//   taken when i_in_valid is high and o_in_stall is low. o_in_stall stays high
//   from that edge until the line's last cell has been loaded for output.
//   output channel: one word per plotted cell, the end cell excluded; the
//   final cell of a line carries last_cell. a line whose start equals its end
//   produces no word at all.
//   timing: an accepted word goes through the setup state, then the walker
//   emits one cell per cycle while the output register can take it. a new
//   line is taken only once the last cell of the previous one is loaded.
//   the single step unit and the one-word output register set this rate.
//   the first cell is visible after setup, once it is loaded for output.
//   stall: while i_out_stall holds a waiting word the walker freezes; no
//   cell is lost or repeated. the next line can be in setup while the last
//   word of the previous one still waits.
//   reset: synchronous, active low; sequencer returns to idle and the
//   output register is emptied.
// ----------------------------------------------------------------------------
module grid_line_rasterizer
    import glr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // sequencer
    t_state r_state;
    t_state n_state;

    // walker state
    t_coord r_x;
    t_coord r_y;
    t_coord r_ex;
    t_coord r_ey;
    t_coord r_adx;
    t_coord r_ady;
    logic   r_up_x;
    logic   r_up_y;
    t_err   r_err;
    logic   r_val;

    // output register
    logic      r_out_valid;
    t_out_word r_out_word;

    t_step_in  w_cur;
    t_step_out w_nxt;
    logic      w_accept;
    logic      w_slot_free;
    logic      w_load;
    logic      w_empty_line;
    t_coord    w_adx;
    t_coord    w_ady;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_load      = (r_state == S_RUN) && w_slot_free;

    // distances of the latched line, worked out in setup
    assign w_adx = (r_ex > r_x) ? r_ex - r_x : r_x - r_ex;
    assign w_ady = (r_ey > r_y) ? r_ey - r_y : r_y - r_ey;
    assign w_empty_line = (r_x == r_ex) && (r_y == r_ey);

    assign w_cur = '{
        x:      r_x,
        y:      r_y,
        err:    r_err,
        end_x:  r_ex,
        end_y:  r_ey,
        abs_dx: r_adx,
        abs_dy: r_ady,
        up_x:   r_up_x,
        up_y:   r_up_y
    };

    glr_step u_step (
        .i_cur (w_cur),
        .o_nxt (w_nxt)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = w_empty_line ? S_IDLE : S_RUN;
            end
            S_RUN: begin
                if (w_load && w_nxt.last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // walker registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x   <= i_in_word.start_x;
            r_y   <= i_in_word.start_y;
            r_ex  <= i_in_word.end_x;
            r_ey  <= i_in_word.end_y;
            r_val <= i_in_word.paint_value;
        end else if (r_state == S_SETUP) begin
            r_adx  <= w_adx;
            r_ady  <= w_ady;
            r_up_x <= (r_x < r_ex);
            r_up_y <= (r_y < r_ey);
            // 2|dy| - |dx| stands for slope minus one half
            r_err  <= t_err'({1'b0, w_ady, 1'b0}) - t_err'({1'b0, w_adx});
        end else if (w_load) begin
            r_x   <= w_nxt.x;
            r_y   <= w_nxt.y;
            r_err <= w_nxt.err;
        end
    end

    // output register: current cell goes out as the walker steps past it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_word.cell_x     <= r_x;
            r_out_word.cell_y     <= r_y;
            r_out_word.cell_value <= r_val;
            r_out_word.last_cell  <= w_nxt.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // an accepted line always passes through setup
    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SETUP))
        else $error("accepted line did not enter setup");

    // the walker never sits on the end cell while running
    a_run_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !w_empty_line)
        else $error("walker running on its end cell");

    // the last cell of a line ends the run
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_nxt.last) |=> (r_state == S_IDLE))
        else $error("run continued past the last cell");

    // each loaded cell moves the walker
    a_walker_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> ((r_x != $past(r_x)) || (r_y != $past(r_y))))
        else $error("walker emitted a cell without moving");

endmodule

// ===== sim/grid_line_rasterizer_test.sv =====
// ----------------------------------------------------------------------------
// grid_line_rasterizer_test - self-checking bench for the grid line rasterizer
// feeds start/end/paint words, predicts every plotted cell of each line and
// checks the output words in order under random idling and stalling
// ----------------------------------------------------------------------------
module grid_line_rasterizer_test;
    import glr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // idle cycles before giving up
    localparam int TAIL_CYCLES    = 80;     // longest line plus setup, with margin
    localparam int RANDOM_LINES   = 480;

    // one pending line and whether the sender drains the output first
    typedef struct {
        t_in_word word;
        bit       drain_first;
    } t_line_job;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    t_line_job pending_lines[$];
    t_out_word expected_cells[$];
    t_line_job next_job;

    int  gap_left     = 0;
    int  stall_left   = 0;
    int  quiet_cycles = 0;
    int  phase_cycles = 0;
    int  fail_count   = 0;
    bit  calm         = 1'b0;   // stretch with no idling on either side

    grid_line_rasterizer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // walk the line as the block should and queue one word per plotted cell
    task automatic trace_line(input t_in_word w);
        int        x, y, ex, ey;
        int        step_x, step_y, run_x, run_y, err, n;
        t_out_word pix;
        x  = w.start_x;
        y  = w.start_y;
        ex = w.end_x;
        ey = w.end_y;
        // coordinates past the grid saturate to its edge
        if (x > GRID_SIZE - 1) x = GRID_SIZE - 1;
        if (y > GRID_SIZE - 1) y = GRID_SIZE - 1;
        if (ex > GRID_SIZE - 1) ex = GRID_SIZE - 1;
        if (ey > GRID_SIZE - 1) ey = GRID_SIZE - 1;
        step_x = (x < ex) ? 1 : -1;
        step_y = (y < ey) ? 1 : -1;
        run_x  = (ex > x) ? ex - x : x - ex;
        run_y  = (ey > y) ? ey - y : y - ey;
        n = 0;
        pix.cell_value = w.paint_value;
        pix.last_cell  = 1'b0;
        // x-major part, error scaled by 2*run_x so the half compare is exact
        if (run_x != 0) begin
            err = 2 * run_y - run_x;
            while (x != ex && n < GRID_SIZE - 1) begin
                pix.cell_x = t_coord'(x);
                pix.cell_y = t_coord'(y);
                expected_cells.push_back(pix);
                n++;
                err += 2 * run_y;
                if (err >= run_x) begin
                    if (y != ey)
                        y += step_y;
                    err -= 2 * run_x;
                end
                x += step_x;
            end
        end
        // vertical run for whatever y distance is left
        while (y != ey && n < GRID_SIZE - 1) begin
            pix.cell_x = t_coord'(x);
            pix.cell_y = t_coord'(y);
            expected_cells.push_back(pix);
            n++;
            y += step_y;
        end
        // mark the final cell of this line
        if (n > 0) begin
            pix = expected_cells.pop_back();
            pix.last_cell = 1'b1;
            expected_cells.push_back(pix);
        end
    endtask

    task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                            input bit paint, input bit drain);
        t_line_job job;
        job.word.start_x     = t_coord'(sx);
        job.word.start_y     = t_coord'(sy);
        job.word.end_x       = t_coord'(ex);
        job.word.end_y       = t_coord'(ey);
        job.word.paint_value = paint;
        job.drain_first      = drain;
        pending_lines.push_back(job);
    endtask

    // sender: a word stays put while stalled, a gap follows each accepted word
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !in_stall)
                trace_line(in_word);
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_lines.size() != 0 &&
                             !(pending_lines[0].drain_first && expected_cells.size() != 0)) begin
                    next_job = pending_lines.pop_front();
                    in_word  <= next_job.word;
                    in_valid <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    // nothing left, or holding off until the output side drains
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each accepted word against the oldest expected cell
    always @(posedge clk) begin
        t_out_word want;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_cells.size() == 0) begin
                    $display("%0t unexpected word: expected none, got x=%0d y=%0d v=%0b last=%0b",
                             $time, out_word.cell_x, out_word.cell_y, out_word.cell_value,
                             out_word.last_cell);
                    fail_count++;
                end else begin
                    want = expected_cells.pop_front();
                    if (out_word.cell_x !== want.cell_x) begin
                        $display("%0t cell_x mismatch: expected %0d, got %0d",
                                 $time, want.cell_x, out_word.cell_x);
                        fail_count++;
                    end
                    if (out_word.cell_y !== want.cell_y) begin
                        $display("%0t cell_y mismatch: expected %0d, got %0d",
                                 $time, want.cell_y, out_word.cell_y);
                        fail_count++;
                    end
                    if (out_word.cell_value !== want.cell_value) begin
                        $display("%0t cell_value mismatch: expected %0b, got %0b",
                                 $time, want.cell_value, out_word.cell_value);
                        fail_count++;
                    end
                    if (out_word.last_cell !== want.last_cell) begin
                        $display("%0t last_cell mismatch: expected %0b, got %0b",
                                 $time, want.last_cell, out_word.last_cell);
                        fail_count++;
                    end
                end
            end
            // stall runs of random length with free cycles between them
            if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 99) < 30)
                    stall_left <= pick_gap();
            end
        end
    end

    // calm stretches come and go; watchdog ends a run that stops moving
    always @(posedge clk) begin
        if (phase_cycles == 499) begin
            phase_cycles <= 0;
            calm         <= ($urandom_range(0, 3) == 0);
        end else begin
            phase_cycles <= phase_cycles + 1;
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("grid_line_rasterizer verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int sx, sy, ex, ey, kind;

        // directed: degenerate, axis-aligned, diagonals, steep and shallow
        add_line(0, 0, 0, 0, 1'b1, 1'b0);       // start equals end
        add_line(63, 63, 63, 63, 1'b0, 1'b0);
        add_line(0, 5, 63, 5, 1'b1, 1'b0);      // horizontal right
        add_line(63, 0, 0, 0, 1'b0, 1'b0);      // horizontal left
        add_line(7, 0, 7, 63, 1'b1, 1'b1);      // vertical down, after a drain
        add_line(7, 63, 7, 0, 1'b0, 1'b0);      // vertical up
        add_line(0, 0, 63, 63, 1'b1, 1'b0);     // full diagonals
        add_line(63, 63, 0, 0, 1'b0, 1'b0);
        add_line(0, 63, 63, 0, 1'b1, 1'b0);
        add_line(63, 0, 0, 63, 1'b0, 1'b0);
        add_line(0, 0, 63, 1, 1'b1, 1'b0);      // very shallow
        add_line(0, 0, 1, 63, 1'b1, 1'b0);      // very steep, mostly vertical run
        add_line(10, 10, 12, 40, 1'b0, 1'b0);
        add_line(40, 50, 35, 20, 1'b1, 1'b0);
        add_line(5, 5, 6, 5, 1'b1, 1'b0);       // single cells
        add_line(5, 5, 5, 6, 1'b0, 1'b0);
        add_line(5, 5, 4, 4, 1'b1, 1'b0);
        add_line(20, 20, 22, 21, 1'b1, 1'b0);   // error lands exactly on one half
        add_line(20, 20, 18, 19, 1'b0, 1'b0);
        add_line(0, 31, 62, 32, 1'b1, 1'b1);
        add_line(21, 42, 42, 21, 1'b1, 1'b0);

        // random: mostly free lines, some short, some degenerate or axis-aligned
        for (int i = 0; i < RANDOM_LINES; i++) begin
            sx   = $urandom_range(0, 63);
            sy   = $urandom_range(0, 63);
            ex   = $urandom_range(0, 63);
            ey   = $urandom_range(0, 63);
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                ex = sx + $urandom_range(0, 6) - 3;
                ey = sy + $urandom_range(0, 6) - 3;
                ex = (ex < 0) ? 0 : (ex > 63) ? 63 : ex;
                ey = (ey < 0) ? 0 : (ey > 63) ? 63 : ey;
            end else if (kind < 28) begin
                ex = sx;
                ey = sy;
            end else if (kind < 33) begin
                ey = sy;
            end else if (kind < 38) begin
                ex = sx;
            end
            add_line(sx, sy, ex, ey, $urandom_range(0, 1),
                     (i == RANDOM_LINES / 2) || ($urandom_range(0, 99) < 2));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // all words handed over, then all cells out, then the latency tail
        while (pending_lines.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_cells.size() == 0) begin
            $display("grid_line_rasterizer verification clean");
        end else begin
            $display("grid_line_rasterizer verification failed");
        end
        $finish;
    end

endmodule
